// ===== rtl/eased_value_ramp_assert.svh =====
// assertion macros for the eased value ramp
`ifndef EASED_VALUE_RAMP_ASSERT_SVH
`define EASED_VALUE_RAMP_ASSERT_SVH

`ifndef ASSERT_OFF

// checked on every edge once reset is released
`define EVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define EVR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define EVR_ASSERT(label, prop, msg)
`define EVR_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== rtl/evr_pkg.sv =====
package evr_pkg;

  localparam int VALUE_W  = 32;
  localparam int TIME_W   = 24;
  localparam int ALPHA_W  = 16;
  localparam int EASE_W   = 16;
  localparam int MAG_W    = VALUE_W + 1;
  localparam int HI_W     = MAG_W - ALPHA_W;
  localparam int MUL_A_W  = (HI_W > 2 * ALPHA_W) ? HI_W : 2 * ALPHA_W;
  localparam int MUL_B_W  = ALPHA_W + 2;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int CNT_W    = $clog2(ALPHA_W);

  // 3.0 in q2.16, the constant term of 3a^2 - 2a^3 after factoring a^2
  localparam logic [MUL_B_W-1:0] POLY_K = MUL_B_W'(3 * (2 ** ALPHA_W));
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ALPHA_W - 1);

  typedef enum logic [0:0] {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } evr_cmd_t;

  typedef struct packed {
    evr_cmd_t                    command;
    logic signed [VALUE_W-1:0]   target_value;
    logic        [TIME_W-1:0]    blend_time;
    logic        [TIME_W-1:0]    delta_time;
  } evr_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]   current_value;
    logic                        blending;
  } evr_out_t;

  typedef struct packed {
    logic                        go;
    logic signed [VALUE_W-1:0]   start_point;
    logic signed [VALUE_W-1:0]   goal_value;
    logic        [TIME_W-1:0]    elapsed;
    logic        [TIME_W-1:0]    duration;
  } evr_calc_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [VALUE_W-1:0]   value;
  } evr_calc_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_OUT
  } evr_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_DIV,
    U_SQ,
    U_POLY,
    U_HI,
    U_LO,
    U_ADD,
    U_DONE
  } evr_ustate_t;

endpackage

// ===== rtl/evr_ease_unit.sv =====
module evr_ease_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  evr_pkg::evr_calc_req_t req,
  output evr_pkg::evr_calc_rsp_t rsp
);

  evr_pkg::evr_ustate_t ustate_r, ustate_nxt;
  logic [evr_pkg::TIME_W-1:0]  rem_r, rem_nxt;
  logic [evr_pkg::ALPHA_W-1:0] quo_r, quo_nxt;
  logic [evr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        neg_r, neg_nxt;
  logic [evr_pkg::MAG_W-1:0]   mag_r, mag_nxt;
  logic [evr_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [evr_pkg::MAG_W-1:0]   hi_r, hi_nxt;
  logic [evr_pkg::EASE_W-1:0]  ease_r, ease_nxt;
  logic [evr_pkg::MAG_W-1:0]   off_r, off_nxt;

  logic [evr_pkg::MAG_W-1:0]   start_x;
  logic [evr_pkg::MAG_W-1:0]   goal_x;
  logic [evr_pkg::MAG_W-1:0]   diff_fw;
  logic [evr_pkg::MAG_W-1:0]   diff_bw;
  logic [evr_pkg::TIME_W:0]    shifted;
  logic                        ge;
  logic [evr_pkg::MUL_A_W-1:0] mul_a;
  logic [evr_pkg::MUL_B_W-1:0] mul_b;
  logic [evr_pkg::PROD_W-1:0]  product;
  logic [evr_pkg::EASE_W-1:0]  ease_w;
  logic [evr_pkg::MAG_W-1:0]   result_x;

  assign start_x = {req.start_point[evr_pkg::VALUE_W-1], req.start_point};
  assign goal_x  = {req.goal_value[evr_pkg::VALUE_W-1], req.goal_value};
  assign diff_fw = goal_x - start_x;
  assign diff_bw = start_x - goal_x;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem_r, 1'b0};
  assign ge      = (shifted >= {1'b0, req.duration});

  assign ease_w  = prod_r[2 * evr_pkg::ALPHA_W +: evr_pkg::EASE_W];
  assign product = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ustate_r)
      evr_pkg::U_SQ: begin
        mul_a = evr_pkg::MUL_A_W'(quo_r);
        mul_b = evr_pkg::MUL_B_W'(quo_r);
      end
      evr_pkg::U_POLY: begin
        mul_a = evr_pkg::MUL_A_W'(prod_r[2 * evr_pkg::ALPHA_W - 1:0]);
        mul_b = evr_pkg::POLY_K - {1'b0, quo_r, 1'b0};
      end
      evr_pkg::U_HI: begin
        mul_a = evr_pkg::MUL_A_W'(mag_r[evr_pkg::MAG_W-1:evr_pkg::ALPHA_W]);
        mul_b = evr_pkg::MUL_B_W'(ease_w);
      end
      evr_pkg::U_LO: begin
        mul_a = evr_pkg::MUL_A_W'(mag_r[evr_pkg::ALPHA_W-1:0]);
        mul_b = evr_pkg::MUL_B_W'(ease_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign result_x = neg_r ? (start_x - off_r) : (start_x + off_r);

  always_comb begin
    ustate_nxt = ustate_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    prod_nxt   = prod_r;
    hi_nxt     = hi_r;
    ease_nxt   = ease_r;
    off_nxt    = off_r;
    rsp.done   = 1'b0;
    rsp.value  = result_x[evr_pkg::VALUE_W-1:0];
    unique case (ustate_r)
      evr_pkg::U_IDLE: begin
        if (req.go) begin
          rem_nxt    = req.elapsed;
          quo_nxt    = '0;
          cnt_nxt    = '0;
          neg_nxt    = diff_fw[evr_pkg::MAG_W-1];
          mag_nxt    = diff_fw[evr_pkg::MAG_W-1] ? diff_bw : diff_fw;
          ustate_nxt = evr_pkg::U_DIV;
        end
      end
      evr_pkg::U_DIV: begin
        rem_nxt = ge ? evr_pkg::TIME_W'(shifted - {1'b0, req.duration})
                     : shifted[evr_pkg::TIME_W-1:0];
        quo_nxt = {quo_r[evr_pkg::ALPHA_W-2:0], ge};
        cnt_nxt = cnt_r + evr_pkg::CNT_W'(1);
        if (cnt_r == evr_pkg::DIV_LAST) begin
          ustate_nxt = evr_pkg::U_SQ;
        end
      end
      evr_pkg::U_SQ: begin
        prod_nxt   = product;
        ustate_nxt = evr_pkg::U_POLY;
      end
      evr_pkg::U_POLY: begin
        prod_nxt   = product;
        ustate_nxt = evr_pkg::U_HI;
      end
      evr_pkg::U_HI: begin
        ease_nxt   = ease_w;
        prod_nxt   = product;
        ustate_nxt = evr_pkg::U_LO;
      end
      evr_pkg::U_LO: begin
        hi_nxt     = prod_r[evr_pkg::MAG_W-1:0];
        prod_nxt   = product;
        ustate_nxt = evr_pkg::U_ADD;
      end
      evr_pkg::U_ADD: begin
        off_nxt    = hi_r + evr_pkg::MAG_W'(prod_r[evr_pkg::ALPHA_W +: evr_pkg::ALPHA_W]);
        ustate_nxt = evr_pkg::U_DONE;
      end
      evr_pkg::U_DONE: begin
        rsp.done   = 1'b1;
        ustate_nxt = evr_pkg::U_IDLE;
      end
      default: begin
        ustate_nxt = evr_pkg::U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ustate_r <= evr_pkg::U_IDLE;
      cnt_r    <= '0;
    end else begin
      ustate_r <= ustate_nxt;
      cnt_r    <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    prod_r <= prod_nxt;
    hi_r   <= hi_nxt;
    ease_r <= ease_nxt;
    off_r  <= off_nxt;
  end

endmodule

// ===== rtl/eased_value_ramp.sv =====
// channel  direction  payload                     handshake
// in_      input      evr_in_t  (set / tick)      in_valid, in_stall
// out_     output     evr_out_t (value, blending) out_valid, out_stall
//
// set, or tick without a blend step: result goes through ST_OUT into the output register
// blending tick: result goes through ST_CALC, then ST_OUT into the output register: 1 start,
//   16 alpha divider steps, 4 multiplier passes, 1 add, 1 done, 1 output load
// in_stall is high from accept until the result is loaded into the output register
// reset (rst_n low, synchronous) clears the ramp state to zero and empties the output
// out_stall holds the output register; one more beat is still taken meanwhile
`include "eased_value_ramp_assert.svh"

module eased_value_ramp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  evr_pkg::evr_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output evr_pkg::evr_out_t out_data
);

  evr_pkg::evr_state_t state_r, state_nxt;
  logic signed [evr_pkg::VALUE_W-1:0] present_r, present_nxt;
  logic signed [evr_pkg::VALUE_W-1:0] start_r, start_nxt;
  logic signed [evr_pkg::VALUE_W-1:0] goal_r, goal_nxt;
  logic [evr_pkg::TIME_W-1:0]         dur_r, dur_nxt;
  logic [evr_pkg::TIME_W-1:0]         elapsed_r, elapsed_nxt;
  logic                               out_valid_r, out_valid_nxt;
  evr_pkg::evr_out_t                  out_data_r, out_data_nxt;

  logic                               in_acc;
  logic                               set_acc;
  logic [evr_pkg::TIME_W:0]           tick_sum;
  evr_pkg::evr_calc_req_t             calc_req;
  evr_pkg::evr_calc_rsp_t             calc_rsp;

  assign in_stall  = (state_r != evr_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign set_acc   = in_acc && (in_data.command == evr_pkg::CMD_SET);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tick_sum = {1'b0, elapsed_r} + {1'b0, in_data.delta_time};

  assign calc_req.go          = (state_r == evr_pkg::ST_CALC);
  assign calc_req.start_point = start_r;
  assign calc_req.goal_value  = goal_r;
  assign calc_req.elapsed     = elapsed_r;
  assign calc_req.duration    = dur_r;

  evr_ease_unit u_ease (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (calc_req),
    .rsp   (calc_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    start_nxt     = start_r;
    goal_nxt      = goal_r;
    dur_nxt       = dur_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      evr_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = evr_pkg::ST_OUT;
          if (in_data.command == evr_pkg::CMD_SET) begin
            start_nxt   = present_r;
            goal_nxt    = in_data.target_value;
            dur_nxt     = in_data.blend_time;
            elapsed_nxt = '0;
            if (in_data.blend_time == '0) begin
              present_nxt = in_data.target_value;
            end
          end else if (dur_r == '0) begin
            present_nxt = goal_r;
          end else if (tick_sum >= {1'b0, dur_r}) begin
            // blend finished: snap to goal
            present_nxt = goal_r;
            dur_nxt     = '0;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = tick_sum[evr_pkg::TIME_W-1:0];
            state_nxt   = evr_pkg::ST_CALC;
          end
        end
      end
      evr_pkg::ST_CALC: begin
        if (calc_rsp.done) begin
          present_nxt = calc_rsp.value;
          state_nxt   = evr_pkg::ST_OUT;
        end
      end
      evr_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.current_value = present_r;
          out_data_nxt.blending      = (dur_r != '0);
          state_nxt                  = evr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = evr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= evr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      present_r   <= '0;
      start_r     <= '0;
      goal_r      <= '0;
      dur_r       <= '0;
      elapsed_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      present_r   <= present_nxt;
      start_r     <= start_nxt;
      goal_r      <= goal_nxt;
      dur_r       <= dur_nxt;
      elapsed_r   <= elapsed_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  `EVR_ASSERT(a_elapsed_below_dur, (dur_r != '0) |-> (elapsed_r < dur_r), "elapsed past duration")
  `EVR_ASSERT(a_idle_elapsed_zero, (dur_r == '0) |-> (elapsed_r == '0), "elapsed without blend")
  `EVR_ASSERT_ALWAYS(a_done_in_calc, calc_rsp.done |-> (state_r == evr_pkg::ST_CALC), "stray done")
  `EVR_ASSERT(a_set_goes_out, set_acc |=> (state_r == evr_pkg::ST_OUT), "set beat not sent out")

endmodule
